>>> sv/otflm_pkg.sv
package otflm_pkg;

	// Default sizes handed to the top level.
	localparam int MAX_CLIENTS_DEF = 16;
	localparam int ID_BITS_DEF     = 16;

	// Fixed field widths.
	localparam int OP_W     = 3;
	localparam int STATUS_W = 4;
	localparam int CFG_W    = 5;

	localparam logic [CFG_W-1:0] MAX_USERS_RESET = 5'd16;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_OPEN   = 3'd0;
	localparam logic [OP_W-1:0] OP_CLOSE  = 3'd1;
	localparam logic [OP_W-1:0] OP_LOCK   = 3'd2;
	localparam logic [OP_W-1:0] OP_UNLOCK = 3'd3;
	localparam logic [OP_W-1:0] OP_QUERY  = 3'd4;

	// Status codes.
	localparam logic [STATUS_W-1:0] ST_DONE           = 4'd0;
	localparam logic [STATUS_W-1:0] ST_ALREADY_OPEN   = 4'd1;
	localparam logic [STATUS_W-1:0] ST_QUEUED         = 4'd2;
	localparam logic [STATUS_W-1:0] ST_BAD_ID         = 4'd3;
	localparam logic [STATUS_W-1:0] ST_FULL           = 4'd4;
	localparam logic [STATUS_W-1:0] ST_NOT_OPEN       = 4'd5;
	localparam logic [STATUS_W-1:0] ST_ALREADY_QUEUED = 4'd6;
	localparam logic [STATUS_W-1:0] ST_CLOSE_LOCKED   = 4'd7;
	localparam logic [STATUS_W-1:0] ST_NOT_QUEUED     = 4'd8;

	// Commands broadcast from the controller to every cell of the row.
	typedef struct packed {
		logic capture;      // latch match flags against the incoming id
		logic open_load;    // append the id at the end of the open table
		logic close_load;   // matching cell takes the last open entry
		logic lock_load;    // append the id at the tail of the lock queue
		logic unlock_shift; // cells at and after the match take their right neighbor
	} cell_cmd_t;

	typedef enum logic {
		CTL_IDLE,
		CTL_UPDATE
	} ctl_state_t;

endpackage

>>> sv/open_table_and_fifo_lock_manager.sv
// Lock manager for one shared resource. Clients are named by a nonzero id. Each client
// first opens the resource (entered in an open table of at most max_users entries, set
// through the configuration port, reset value 16), may then lock it (the first in a FIFO
// lock queue holds the lock, later ones wait), unlock it (leaving the queue from any place,
// the result names the next holder when the lock moves) and close it. Every input
// transaction yields exactly one output transaction carrying a status code, the newly
// granted client, the holder, the open count and the caller's open and queued flags after
// the operation. An operation has an acceptance, in which every cell of the row compares
// its entries against the id, and an update state, in which the controller decides and
// the cells shift or load; the input is stalled from acceptance until the update is done,
// so no new operation is taken before the last one is through. The result sits in
// an output register, so the next operation is taken while the previous result waits;
// the update state stretches only while an older result is still stalled. Writes to the
// max_users register are taken at any time but should be made while the block is idle.
module open_table_and_fifo_lock_manager import otflm_pkg::*; #(
	parameter int MAX_CLIENTS = MAX_CLIENTS_DEF,
	parameter int ID_BITS     = ID_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Configuration write channel.
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [CFG_W-1:0]                  cfg_data,
	// Input channel.
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [OP_W-1:0]                   op,
	input  logic [ID_BITS-1:0]                client_id,
	// Output channel.
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [STATUS_W-1:0]               status,
	output logic [ID_BITS-1:0]                granted_id,
	output logic [ID_BITS-1:0]                holder_id,
	output logic [$clog2(MAX_CLIENTS+1)-1:0]  open_count,
	output logic                              is_open,
	output logic                              in_queue
);

	localparam int CNTW = $clog2(MAX_CLIENTS+1);
	localparam int LIMW = (CNTW > CFG_W) ? CNTW : CFG_W;
	localparam logic [CNTW-1:0] CNT_MAX = CNTW'(MAX_CLIENTS);
	localparam logic [LIMW-1:0] LIM_MAX = LIMW'(MAX_CLIENTS);

	ctl_state_t state_q, state_d;

	logic [CFG_W-1:0]    max_users_q;
	logic [OP_W-1:0]     op_q;
	logic [ID_BITS-1:0]  id_q;
	logic [ID_BITS-1:0]  last_open_q;
	logic [CNTW-1:0]     open_total_q;
	logic [CNTW-1:0]     queue_total_q;

	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [ID_BITS-1:0]  granted_q;
	logic [ID_BITS-1:0]  holder_q;
	logic [CNTW-1:0]     count_q;
	logic                is_open_q;
	logic                in_queue_q;

	// Row wiring.
	cell_cmd_t           cmd;
	logic [ID_BITS-1:0]  last_chain [MAX_CLIENTS];
	logic                seen_chain [MAX_CLIENTS];
	logic [ID_BITS-1:0]  qdata      [MAX_CLIENTS];
	logic [MAX_CLIENTS-1:0] omatch_vec;
	logic [MAX_CLIENTS-1:0] qmatch_vec;
	logic [ID_BITS-1:0]  head_next;

	// Decision signals.
	logic                accept;
	logic                commit;
	logic                found_open;
	logic                found_queue;
	logic                table_full;
	logic [LIMW-1:0]     cfg_ext;
	logic [LIMW-1:0]     limit;
	logic [ID_BITS-1:0]  cur_holder;
	logic [STATUS_W-1:0] status_d;
	logic [ID_BITS-1:0]  granted_d;
	logic [ID_BITS-1:0]  holder_d;
	logic [CNTW-1:0]     open_total_d;
	logic [CNTW-1:0]     queue_total_d;
	logic                is_open_d;
	logic                in_queue_d;
	logic                do_open;
	logic                do_close;
	logic                do_lock;
	logic                do_unlock;

	// The row of cells. Cell i holds open-table entry i and lock-queue entry i. The last
	// open entry is ORed along the row toward the end, and the "match seen" flag of the
	// lock queue runs the same way so that every cell at or after the leaving client
	// takes the entry of its right neighbor on an unlock.
	for (genvar i = 0; i < MAX_CLIENTS; i++) begin : g_row
		logic [ID_BITS-1:0] last_in_w;
		logic               seen_in_w;
		logic [ID_BITS-1:0] qnext_w;

		if (i == 0) begin : g_first
			assign last_in_w = '0;
			assign seen_in_w = 1'b0;
		end else begin : g_link
			assign last_in_w = last_chain[i-1];
			assign seen_in_w = seen_chain[i-1];
		end

		if (i == MAX_CLIENTS - 1) begin : g_tail
			assign qnext_w = '0;
		end else begin : g_mid
			assign qnext_w = qdata[i+1];
		end

		otflm_cell #(
			.MAX_CLIENTS (MAX_CLIENTS),
			.ID_BITS     (ID_BITS),
			.IDX         (i)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.cmd         (cmd),
			.cmp_id      (client_id),
			.wr_id       (id_q),
			.open_total  (open_total_q),
			.queue_total (queue_total_q),
			.last_open   (last_open_q),
			.last_in     (last_in_w),
			.last_out    (last_chain[i]),
			.seen_in     (seen_in_w),
			.seen_out    (seen_chain[i]),
			.qnext       (qnext_w),
			.qdata       (qdata[i]),
			.omatch      (omatch_vec[i]),
			.qmatch      (qmatch_vec[i])
		);
	end

	// The waiter right behind the holder, who takes the lock when the holder leaves.
	if (MAX_CLIENTS > 1) begin : g_head_next
		assign head_next = qdata[1];
	end else begin : g_head_none
		assign head_next = '0;
	end

	// The register is always writable; the block relies on writes arriving while idle.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_users_q <= MAX_USERS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			max_users_q <= cfg_data;
		end
	end

	// Handshake and sequencing. An operation is accepted only in the idle state and is
	// resolved in the update state, which waits only while an earlier result is stalled.
	assign accept = in_valid && !in_stall;
	assign commit = (state_q == CTL_UPDATE) && (!out_valid_q || !out_stall);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			CTL_IDLE: begin
				if (accept) begin
					state_d = CTL_UPDATE;
				end
			end
			CTL_UPDATE: begin
				if (commit) begin
					state_d = CTL_IDLE;
				end
			end
			default: state_d = CTL_IDLE;
		endcase
	end

	always_comb begin
		in_stall         = (state_q != CTL_IDLE);
		cmd.capture      = accept;
		cmd.open_load    = commit && do_open;
		cmd.close_load   = commit && do_close;
		cmd.lock_load    = commit && do_lock;
		cmd.unlock_shift = commit && do_unlock;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CTL_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// The operation and the last open entry are captured together with the match flags.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q        <= op;
			id_q        <= client_id;
			last_open_q <= last_chain[MAX_CLIENTS-1];
		end
	end

	assign found_open  = |omatch_vec;
	assign found_queue = |qmatch_vec;
	assign cur_holder  = (queue_total_q != '0) ? qdata[0] : '0;

	// A limit of zero acts as one, and a limit above the table size acts as the table size.
	// A table holding more entries than a lowered limit simply counts as full.
	always_comb begin
		cfg_ext = LIMW'(max_users_q);
		if (cfg_ext == '0) begin
			limit = LIMW'(1);
		end else if (cfg_ext > LIM_MAX) begin
			limit = LIM_MAX;
		end else begin
			limit = cfg_ext;
		end
		table_full = LIMW'(open_total_q) >= limit;
	end

	// Decision for the captured operation, from the match flags the cells latched.
	always_comb begin
		status_d      = ST_DONE;
		granted_d     = '0;
		holder_d      = cur_holder;
		open_total_d  = open_total_q;
		queue_total_d = queue_total_q;
		is_open_d     = found_open;
		in_queue_d    = found_queue;
		do_open       = 1'b0;
		do_close      = 1'b0;
		do_lock       = 1'b0;
		do_unlock     = 1'b0;

		if (id_q == '0) begin
			// A zero id is refused for every operation, query included.
			status_d   = ST_BAD_ID;
			is_open_d  = 1'b0;
			in_queue_d = 1'b0;
		end else begin
			unique case (op_q)
				OP_OPEN: begin
					// The full check comes before the duplicate check.
					if (table_full) begin
						status_d = ST_FULL;
					end else if (found_open) begin
						status_d = ST_ALREADY_OPEN;
					end else begin
						do_open      = 1'b1;
						open_total_d = open_total_q + CNTW'(1);
						is_open_d    = 1'b1;
					end
				end
				OP_CLOSE: begin
					if (found_open && found_queue) begin
						status_d = ST_CLOSE_LOCKED;
					end else if (!found_open) begin
						status_d = ST_NOT_OPEN;
					end else begin
						// The last entry moves into the slot of the leaving client.
						do_close     = 1'b1;
						open_total_d = open_total_q - CNTW'(1);
						is_open_d    = 1'b0;
					end
				end
				OP_LOCK: begin
					if (!found_open) begin
						status_d = ST_NOT_OPEN;
					end else if (found_queue) begin
						status_d = ST_ALREADY_QUEUED;
					end else if (queue_total_q >= CNT_MAX) begin
						status_d = ST_FULL;
					end else begin
						do_lock       = 1'b1;
						queue_total_d = queue_total_q + CNTW'(1);
						in_queue_d    = 1'b1;
						if (queue_total_q == '0) begin
							holder_d = id_q;
						end else begin
							status_d = ST_QUEUED;
						end
					end
				end
				OP_UNLOCK: begin
					if (!found_open) begin
						status_d = ST_NOT_OPEN;
					end else if (!found_queue) begin
						status_d = ST_NOT_QUEUED;
					end else begin
						do_unlock     = 1'b1;
						queue_total_d = queue_total_q - CNTW'(1);
						in_queue_d    = 1'b0;
						if (queue_total_d == '0) begin
							holder_d = '0;
						end else if (cur_holder == id_q) begin
							// The holder left while others wait: the next one takes the lock.
							holder_d  = head_next;
							granted_d = head_next;
						end
					end
				end
				default: begin
					// Query and unused codes change nothing.
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_total_q  <= '0;
			queue_total_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (commit) begin
				open_total_q  <= open_total_d;
				queue_total_q <= queue_total_d;
				out_valid_q   <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q   <= 1'b0;
			end
		end
	end

	// Output register; it only changes when a result is committed.
	always_ff @(posedge clk) begin
		if (commit) begin
			status_q   <= status_d;
			granted_q  <= granted_d;
			holder_q   <= holder_d;
			count_q    <= open_total_d;
			is_open_q  <= is_open_d;
			in_queue_q <= in_queue_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign granted_id = granted_q;
	assign holder_id  = holder_q;
	assign open_count = count_q;
	assign is_open    = is_open_q;
	assign in_queue   = in_queue_q;

endmodule

>>> sv/otflm_cell.sv
module otflm_cell import otflm_pkg::*; #(
	parameter int MAX_CLIENTS = MAX_CLIENTS_DEF,
	parameter int ID_BITS     = ID_BITS_DEF,
	parameter int IDX         = 0
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  cell_cmd_t                            cmd,
	input  logic [ID_BITS-1:0]                   cmp_id,
	input  logic [ID_BITS-1:0]                   wr_id,
	input  logic [$clog2(MAX_CLIENTS+1)-1:0]     open_total,
	input  logic [$clog2(MAX_CLIENTS+1)-1:0]     queue_total,
	input  logic [ID_BITS-1:0]                   last_open,
	input  logic [ID_BITS-1:0]                   last_in,
	output logic [ID_BITS-1:0]                   last_out,
	input  logic                                 seen_in,
	output logic                                 seen_out,
	input  logic [ID_BITS-1:0]                   qnext,
	output logic [ID_BITS-1:0]                   qdata,
	output logic                                 omatch,
	output logic                                 qmatch
);

	localparam int CNTW = $clog2(MAX_CLIENTS+1);
	localparam logic [CNTW-1:0] MY_IDX  = CNTW'(IDX);
	localparam logic [CNTW-1:0] MY_NEXT = CNTW'(IDX + 1);

	logic [ID_BITS-1:0] open_q;
	logic [ID_BITS-1:0] queue_q;
	logic               omatch_q;
	logic               qmatch_q;
	logic               in_open;
	logic               in_queue_range;

	assign in_open        = MY_IDX < open_total;
	assign in_queue_range = MY_IDX < queue_total;

	// The entry just below the fill count is the last open entry; the row ORs it toward the end.
	assign last_out = last_in | ((MY_NEXT == open_total) ? open_q : '0);
	assign seen_out = seen_in | qmatch_q;
	assign qdata    = queue_q;
	assign omatch   = omatch_q;
	assign qmatch   = qmatch_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			omatch_q <= 1'b0;
			qmatch_q <= 1'b0;
		end else if (cmd.capture) begin
			omatch_q <= in_open && (open_q == cmp_id);
			qmatch_q <= in_queue_range && (queue_q == cmp_id);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.open_load && (MY_IDX == open_total)) begin
			open_q <= wr_id;
		end else if (cmd.close_load && omatch_q) begin
			open_q <= last_open;
		end
		if (cmd.lock_load && (MY_IDX == queue_total)) begin
			queue_q <= wr_id;
		end else if (cmd.unlock_shift && seen_out) begin
			queue_q <= qnext;
		end
	end

endmodule

>>> sv/otflm_check.sv
module otflm_check import otflm_pkg::*; #(
	parameter int MAX_CLIENTS = MAX_CLIENTS_DEF,
	parameter int ID_BITS     = ID_BITS_DEF
) (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_stall,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic [STATUS_W-1:0]               status,
	input logic [ID_BITS-1:0]                granted_id,
	input logic [ID_BITS-1:0]                holder_id,
	input logic [$clog2(MAX_CLIENTS+1)-1:0]  open_count,
	input logic                              is_open,
	input logic                              in_queue
);

	// One operation at a time: an accepted transaction blocks the next cycle.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input accepted in back-to-back cycles");

	// A stalled result holds its status, grant, holder and open count.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(status) && $stable(granted_id)
			&& $stable(holder_id) && $stable(open_count)))
		else $error("stalled result changed");

	// A newly granted client is the holder reported with it.
	a_grant_is_holder: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && granted_id != '0) |-> (holder_id == granted_id && status == ST_DONE))
		else $error("granted client differs from holder");

	// A queued waiter is open, queued and stands behind a holder.
	a_queued_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_QUEUED) |-> (is_open && in_queue && holder_id != '0))
		else $error("queued result with inconsistent flags");

	// A refused zero id reports neither open nor queued.
	a_bad_id_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_BAD_ID) |-> (!is_open && !in_queue))
		else $error("zero id reported as open or queued");

endmodule

bind open_table_and_fifo_lock_manager otflm_check #(
	.MAX_CLIENTS (MAX_CLIENTS),
	.ID_BITS     (ID_BITS)
) u_otflm_check (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.status     (status),
	.granted_id (granted_id),
	.holder_id  (holder_id),
	.open_count (open_count),
	.is_open    (is_open),
	.in_queue   (in_queue)
);
